[hdl/tapa_pkg.sv]
// ----------------------------------------------------------------------------
// tapa_pkg: shared definitions for the three-angle projection accumulator
// Sizes, field widths, function and selector codes, the clear-sequencer
// status type and the saturating add used by the read-modify-write stage.
// ----------------------------------------------------------------------------
package tapa_pkg;

  localparam int SPATIAL_SIZE  = 256;
  localparam int SPECTRAL_SIZE = 64;
  localparam int SLANT_BINS    = SPATIAL_SIZE + SPECTRAL_SIZE - 1;

  localparam int SUM_W      = 24;
  localparam int PIX_W      = 16;
  localparam int SPATIAL_W  = 8;
  localparam int SPECTRAL_W = 6;
  localparam int SEL_W      = 2;
  localparam int BIN_W      = 9;

  localparam int COL_AW   = $clog2(SPATIAL_SIZE);
  localparam int SLANT_AW = $clog2(SLANT_BINS);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [0:0] {
    FUNC_ACCUM = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  localparam logic [SEL_W-1:0] ORDER_COLUMN = 2'd0;
  localparam logic [SEL_W-1:0] ORDER_DIAG   = 2'd1;
  localparam logic [SEL_W-1:0] ORDER_ANTI   = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_BIN = 1'b1;

  // Status of the post-reset clearing sweep.
  typedef struct packed {
    logic                busy;
    logic [SLANT_AW-1:0] addr;
  } clr_t;

  // Adds a pixel to a bin and clamps the result at the largest sum.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] old_sum,
                                               input logic [PIX_W-1:0] pix);
    logic [SUM_W:0] sum;
    sum = {1'b0, old_sum} + (SUM_W + 1)'(pix);
    return sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
  endfunction

endpackage

[hdl/tapa_if.sv]
// ----------------------------------------------------------------------------
// tapa_if: item channels of the projection accumulator
// Valid/ready channels for the pixel and request items and for the results.
// ----------------------------------------------------------------------------
interface tapa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [0:0]                           func;
  logic [tapa_pkg::PIX_W-1:0]           pixel_value;
  logic [tapa_pkg::SPATIAL_W-1:0]       spatial_index;
  logic [tapa_pkg::SPECTRAL_W-1:0]      spectral_index;
  logic [tapa_pkg::SEL_W-1:0]           order_select;
  logic [tapa_pkg::BIN_W-1:0]           bin_index;

  modport source (output valid, func, pixel_value, spatial_index, spectral_index,
                  order_select, bin_index, input ready);
  modport sink   (input valid, func, pixel_value, spatial_index, spectral_index,
                  order_select, bin_index, output ready);
endinterface

interface tapa_out_if;
  logic                       valid;
  logic                       ready;
  logic [tapa_pkg::SUM_W-1:0] read_sum;
  logic                       status;

  modport source (output valid, read_sum, status, input ready);
  modport sink   (input valid, read_sum, status, output ready);
endinterface

[hdl/tapa_ram.sv]
// ----------------------------------------------------------------------------
// tapa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module tapa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/tapa_clear.sv]
// ----------------------------------------------------------------------------
// tapa_clear: post-reset clearing sweep
// Walks every bin address once after reset so the sum stores start at zero.
// ----------------------------------------------------------------------------
module tapa_clear (
  input  logic           clk,
  input  logic           rst_n,
  output tapa_pkg::clr_t clr
);

  localparam logic [tapa_pkg::SLANT_AW-1:0] LAST_ADDR =
    tapa_pkg::SLANT_AW'(tapa_pkg::SLANT_BINS - 1);

  logic                          busy_r;
  logic [tapa_pkg::SLANT_AW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST_ADDR) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign clr.busy = busy_r;
  assign clr.addr = cnt_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (32'(cnt_r) < tapa_pkg::SLANT_BINS))
    else $error("clear sweep address beyond the slant store");

  assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> !busy_r)
    else $error("clear sweep restarted without a reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r != LAST_ADDR) |=> (busy_r && cnt_r == $past(cnt_r) + 1'b1))
    else $error("clear sweep skipped an address");

endmodule

[hdl/three_angle_projection_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// three_angle_projection_accumulator_unit: column and slant projection sums
// Adds each pixel into a column, a diagonal and an antidiagonal sum store and
// answers read-and-clear requests for one bin of a chosen store.
// ----------------------------------------------------------------------------
// A read request is read from its store at the accept edge, then passes the
// modify/write stage into the output register; a full output register holds it.
// Throughput: one item per cycle, set by the one read-modify-write stage per
// store; same-bin hits are forwarded, and outside the clearing sweep the input
// stalls only while a read item waits behind a result in the output register.
// Reset: synchronous, active low; then a sweep zeroes all stores, in_ch.ready low.
// ----------------------------------------------------------------------------
module three_angle_projection_accumulator_unit (
  input  logic      clk,
  input  logic      rst_n,
  tapa_in_if.sink   in_ch,
  tapa_out_if.source out_ch
);

  localparam int NSTORE = 3;
  localparam int AW     = tapa_pkg::SLANT_AW;
  localparam int SW     = tapa_pkg::SUM_W;

  // Store numbering inside the datapath: column, diagonal, antidiagonal.
  localparam int S_COL  = 0;
  localparam int S_DIAG = 1;
  localparam int S_ANTI = 2;

  tapa_pkg::clr_t clr;

  tapa_clear u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  // --------------------------------------------------------------------------
  // Request decode. Every store gets an address and a write flag; the slant
  // stores share the wider address width, the column store uses the low bits.
  // --------------------------------------------------------------------------
  logic                    in_fire;
  logic                    is_read;
  logic                    coord_ok;
  logic                    bin_err;
  logic [NSTORE-1:0]       sel_hit;
  logic [AW-1:0]           acc_addr [NSTORE];
  logic [AW-1:0]           new_addr [NSTORE];
  logic [NSTORE-1:0]       new_we;

  assign is_read  = (in_ch.func == tapa_pkg::FUNC_READ);
  assign coord_ok = (32'(in_ch.spatial_index) < tapa_pkg::SPATIAL_SIZE) &&
                    (32'(in_ch.spectral_index) < tapa_pkg::SPECTRAL_SIZE);

  assign sel_hit[S_COL]  = (in_ch.order_select == tapa_pkg::ORDER_COLUMN);
  assign sel_hit[S_DIAG] = (in_ch.order_select == tapa_pkg::ORDER_DIAG);
  assign sel_hit[S_ANTI] = (in_ch.order_select == tapa_pkg::ORDER_ANTI);

  always_comb begin
    if (sel_hit[S_COL]) begin
      bin_err = !(32'(in_ch.bin_index) < tapa_pkg::SPATIAL_SIZE);
    end else if (sel_hit[S_DIAG] || sel_hit[S_ANTI]) begin
      bin_err = !(32'(in_ch.bin_index) < tapa_pkg::SLANT_BINS);
    end else begin
      bin_err = 1'b1;
    end
  end

  assign acc_addr[S_COL]  = AW'(in_ch.spatial_index);
  assign acc_addr[S_DIAG] = AW'(in_ch.spatial_index) + AW'(tapa_pkg::SPECTRAL_SIZE - 1)
                            - AW'(in_ch.spectral_index);
  assign acc_addr[S_ANTI] = AW'(in_ch.spatial_index) + AW'(in_ch.spectral_index);

  always_comb begin
    for (int k = 0; k < NSTORE; k++) begin
      new_addr[k] = is_read ? AW'(in_ch.bin_index) : acc_addr[k];
      new_we[k]   = is_read ? (!bin_err && sel_hit[k]) : coord_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Modify/write stage. The RAM data of an item is registered at the edge that
  // accepts it. If the item ahead wrote the same bin on the edge of that read,
  // the RAM returned the stale value, so the written value is captured at
  // accept time and used instead.
  // --------------------------------------------------------------------------
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic                          s1_read_r;
  logic                          s1_err_r;
  logic [tapa_pkg::SEL_W-1:0]    s1_sel_r;
  logic [tapa_pkg::PIX_W-1:0]    s1_pix_r;
  logic [AW-1:0]                 s1_addr_r [NSTORE];
  logic [NSTORE-1:0]             s1_we_r;
  logic [NSTORE-1:0]             s1_hit_r;
  logic [SW-1:0]                 s1_fwd_r  [NSTORE];

  logic [SW-1:0]                 rd_data   [NSTORE];
  logic [SW-1:0]                 old_sum   [NSTORE];
  logic [SW-1:0]                 new_sum   [NSTORE];
  logic [NSTORE-1:0]             hit;

  logic                          out_valid_r;
  logic [SW-1:0]                 out_sum_r;
  logic                          out_status_r;
  logic                          out_free;
  logic                          s1_go;
  logic [SW-1:0]                 sel_sum;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!s1_read_r || out_free);

  // The input waits during the clearing sweep and while the stage is stuck
  // behind a full output register.
  assign in_ch.ready = !clr.busy && !(s1_valid_r && !s1_go);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    for (int k = 0; k < NSTORE; k++) begin
      old_sum[k] = s1_hit_r[k] ? s1_fwd_r[k] : rd_data[k];
      new_sum[k] = s1_read_r ? '0 : tapa_pkg::sat_add(old_sum[k], s1_pix_r);
      hit[k]     = s1_go && s1_we_r[k] && (s1_addr_r[k] == new_addr[k]);
    end
  end

  always_comb begin
    case (s1_sel_r)
      tapa_pkg::ORDER_COLUMN: sel_sum = old_sum[S_COL];
      tapa_pkg::ORDER_DIAG:   sel_sum = old_sum[S_DIAG];
      tapa_pkg::ORDER_ANTI:   sel_sum = old_sum[S_ANTI];
      default:                sel_sum = '0;
    endcase
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_fire) begin
      s1_read_r <= is_read;
      s1_err_r  <= bin_err;
      s1_sel_r  <= in_ch.order_select;
      s1_pix_r  <= in_ch.pixel_value;
      s1_we_r   <= new_we;
      s1_hit_r  <= hit;
      for (int k = 0; k < NSTORE; k++) begin
        s1_addr_r[k] <= new_addr[k];
        s1_fwd_r[k]  <= new_sum[k];
      end
    end
  end

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_read_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && s1_read_r) begin
      out_sum_r    <= s1_err_r ? '0 : sel_sum;
      out_status_r <= s1_err_r ? tapa_pkg::STATUS_BAD_BIN : tapa_pkg::STATUS_OK;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.read_sum = out_sum_r;
  assign out_ch.status   = out_status_r;

  // --------------------------------------------------------------------------
  // Sum stores. During the sweep every store is written with zero; the column
  // store only for addresses it actually has.
  // --------------------------------------------------------------------------
  logic [NSTORE-1:0] ram_we;
  logic [AW-1:0]     ram_waddr [NSTORE];
  logic [SW-1:0]     ram_wdata [NSTORE];
  logic [NSTORE-1:0] ram_re;

  always_comb begin
    for (int k = 0; k < NSTORE; k++) begin
      if (clr.busy) begin
        ram_we[k]    = (k != S_COL) || (32'(clr.addr) < tapa_pkg::SPATIAL_SIZE);
        ram_waddr[k] = clr.addr;
        ram_wdata[k] = '0;
      end else begin
        ram_we[k]    = s1_go && s1_we_r[k];
        ram_waddr[k] = s1_addr_r[k];
        ram_wdata[k] = new_sum[k];
      end
      ram_re[k] = in_fire && new_we[k];
    end
  end

  tapa_ram #(
    .WIDTH (SW),
    .DEPTH (tapa_pkg::SPATIAL_SIZE)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we[S_COL]),
    .waddr (ram_waddr[S_COL][tapa_pkg::COL_AW-1:0]),
    .wdata (ram_wdata[S_COL]),
    .re    (ram_re[S_COL]),
    .raddr (new_addr[S_COL][tapa_pkg::COL_AW-1:0]),
    .rdata (rd_data[S_COL])
  );

  tapa_ram #(
    .WIDTH (SW),
    .DEPTH (tapa_pkg::SLANT_BINS)
  ) u_diag_ram (
    .clk   (clk),
    .we    (ram_we[S_DIAG]),
    .waddr (ram_waddr[S_DIAG]),
    .wdata (ram_wdata[S_DIAG]),
    .re    (ram_re[S_DIAG]),
    .raddr (new_addr[S_DIAG]),
    .rdata (rd_data[S_DIAG])
  );

  tapa_ram #(
    .WIDTH (SW),
    .DEPTH (tapa_pkg::SLANT_BINS)
  ) u_anti_ram (
    .clk   (clk),
    .we    (ram_we[S_ANTI]),
    .waddr (ram_waddr[S_ANTI]),
    .wdata (ram_wdata[S_ANTI]),
    .re    (ram_re[S_ANTI]),
    .raddr (new_addr[S_ANTI]),
    .rdata (rd_data[S_ANTI])
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assert property (@(posedge clk) disable iff (!rst_n)
    clr.busy |-> (!in_ch.ready && !s1_valid_r))
    else $error("item taken or in flight during the clearing sweep");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=>
      (s1_valid_r && $stable(s1_pix_r) && $stable(s1_addr_r[S_DIAG]) &&
       $stable(rd_data[S_DIAG])))
    else $error("stalled read-modify-write item changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == tapa_pkg::STATUS_BAD_BIN) |-> (out_sum_r == '0))
    else $error("bad-bin result carries a nonzero sum");

  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we[S_DIAG] || ram_we[S_ANTI]) |->
      (32'(ram_waddr[S_DIAG]) < tapa_pkg::SLANT_BINS || !ram_we[S_DIAG]) &&
      (32'(ram_waddr[S_ANTI]) < tapa_pkg::SLANT_BINS || !ram_we[S_ANTI]))
    else $error("slant store write beyond its depth");

endmodule

[bench/projection_sum_checker.sv]
// ----------------------------------------------------------------------------
// projection_sum_checker: scoreboard for the projection accumulator
// Keeps its own copy of the column, diagonal and antidiagonal sums, predicts
// the answer to every read item and compares it with the result channel.
// ----------------------------------------------------------------------------
module projection_sum_checker (
  input  logic clk,
  input  logic rst_n,
  tapa_in_if   pix_ch,
  tapa_out_if  sum_ch,
  output int   mismatches,
  output int   reads_owed
);

  typedef struct {
    logic [tapa_pkg::SUM_W-1:0] sum;
    logic                       status;
  } bin_answer_t;

  logic [tapa_pkg::SUM_W-1:0] col_sum  [tapa_pkg::SPATIAL_SIZE];
  logic [tapa_pkg::SUM_W-1:0] diag_sum [tapa_pkg::SLANT_BINS];
  logic [tapa_pkg::SUM_W-1:0] anti_sum [tapa_pkg::SLANT_BINS];

  bin_answer_t answers_due[$];

  // Adds a pixel to a sum and holds the sum at full scale on overflow.
  function automatic logic [tapa_pkg::SUM_W-1:0] clamp_add(
      input logic [tapa_pkg::SUM_W-1:0] acc,
      input logic [tapa_pkg::PIX_W-1:0] pix);
    int unsigned total;
    total = int'(acc) + int'(pix);
    if (total > int'(tapa_pkg::SUM_MAX)) begin
      return tapa_pkg::SUM_MAX;
    end
    return total[tapa_pkg::SUM_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    bin_answer_t got;
    bin_answer_t want;
    int          sp;
    int          sc;
    int          bin;
    int          bad;

    if (!rst_n) begin
      foreach (col_sum[i]) col_sum[i] = '0;
      foreach (diag_sum[i]) diag_sum[i] = '0;
      foreach (anti_sum[i]) anti_sum[i] = '0;
      answers_due.delete();
      mismatches <= 0;
    end else begin
      bad = 0;
      // A result never reaches the result channel in the cycle its request is
      // accepted, so the result side is handled first.
      if (sum_ch.valid && sum_ch.ready) begin
        got.sum    = sum_ch.read_sum;
        got.status = sum_ch.status;
        if (answers_due.size() == 0) begin
          $error("result with no read waiting: read_sum %0d status %0d",
                 got.sum, got.status);
          bad = bad + 1;
        end else begin
          want = answers_due.pop_front();
          if (got.sum !== want.sum) begin
            $error("read_sum: expected %0d, actual %0d", want.sum, got.sum);
            bad = bad + 1;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            bad = bad + 1;
          end
        end
      end

      if (pix_ch.valid && pix_ch.ready) begin
        sp  = int'(pix_ch.spatial_index);
        sc  = int'(pix_ch.spectral_index);
        bin = int'(pix_ch.bin_index);
        if (pix_ch.func == tapa_pkg::FUNC_ACCUM) begin
          if (sp < tapa_pkg::SPATIAL_SIZE && sc < tapa_pkg::SPECTRAL_SIZE) begin
            col_sum[sp] = clamp_add(col_sum[sp], pix_ch.pixel_value);
            diag_sum[sp + tapa_pkg::SPECTRAL_SIZE - 1 - sc] =
              clamp_add(diag_sum[sp + tapa_pkg::SPECTRAL_SIZE - 1 - sc],
                        pix_ch.pixel_value);
            anti_sum[sp + sc] = clamp_add(anti_sum[sp + sc], pix_ch.pixel_value);
          end
        end else begin
          want.sum    = '0;
          want.status = tapa_pkg::STATUS_BAD_BIN;
          case (pix_ch.order_select)
            tapa_pkg::ORDER_COLUMN: begin
              if (bin < tapa_pkg::SPATIAL_SIZE) begin
                want.sum    = col_sum[bin];
                want.status = tapa_pkg::STATUS_OK;
                col_sum[bin] = '0;
              end
            end
            tapa_pkg::ORDER_DIAG: begin
              if (bin < tapa_pkg::SLANT_BINS) begin
                want.sum    = diag_sum[bin];
                want.status = tapa_pkg::STATUS_OK;
                diag_sum[bin] = '0;
              end
            end
            tapa_pkg::ORDER_ANTI: begin
              if (bin < tapa_pkg::SLANT_BINS) begin
                want.sum    = anti_sum[bin];
                want.status = tapa_pkg::STATUS_OK;
                anti_sum[bin] = '0;
              end
            end
            default: ;
          endcase
          answers_due.push_back(want);
        end
      end
      mismatches <= mismatches + bad;
    end
    reads_owed <= answers_due.size();
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: top level of the projection accumulator testbench
// Drives pixel and read items with random gaps and result back-pressure,
// lets the checker predict and compare, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  // The selector code that names no store; the block must reject it.
  localparam logic [tapa_pkg::SEL_W-1:0] ORDER_NONE = 2'd3;

  // Longest run of cycles with no item moving on either channel. The reset
  // sweep and the random gaps are both much shorter, so this is generous.
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n;

  // When set, neither side inserts gaps or stalls.
  bit steady = 1'b0;

  int mismatches;
  int reads_owed;
  int quiet_cycles = 0;

  tapa_in_if  in_ch ();
  tapa_out_if out_ch ();

  three_angle_projection_accumulator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  projection_sum_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_ch     (in_ch),
    .sum_ch     (out_ch),
    .mismatches (mismatches),
    .reads_owed (reads_owed)
  );

  always #2 clk = ~clk;

  // The result side stalls about 38 percent of the time unless the bench
  // is in its steady stretch.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 38);
  end

  // The watchdog ends the run when nothing has moved for too long. Reset and
  // the clearing sweep count toward it too, which the limit allows for.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL three_angle_projection_accumulator_unit");
      $finish;
    end
  end

  // Presents one item and returns at the edge where it is accepted. Valid is
  // left high on return so that a following item can go out back to back;
  // it is only lowered inside a gap, never in the same step it is raised.
  task automatic send_item(input tapa_pkg::func_t f,
                           input logic [tapa_pkg::PIX_W-1:0] pix,
                           input logic [tapa_pkg::SPATIAL_W-1:0] sp,
                           input logic [tapa_pkg::SPECTRAL_W-1:0] sc,
                           input logic [tapa_pkg::SEL_W-1:0] sel,
                           input logic [tapa_pkg::BIN_W-1:0] bin);
    while (!steady && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= f;
    in_ch.pixel_value    <= pix;
    in_ch.spatial_index  <= sp;
    in_ch.spectral_index <= sc;
    in_ch.order_select   <= sel;
    in_ch.bin_index      <= bin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // A pixel item; the read fields carry random values the block must ignore.
  task automatic accumulate(input logic [tapa_pkg::PIX_W-1:0] pix,
                            input logic [tapa_pkg::SPATIAL_W-1:0] sp,
                            input logic [tapa_pkg::SPECTRAL_W-1:0] sc);
    send_item(tapa_pkg::FUNC_ACCUM, pix, sp, sc, tapa_pkg::SEL_W'($urandom),
              tapa_pkg::BIN_W'($urandom));
  endtask

  // A read item; the pixel fields carry random values the block must ignore.
  task automatic read_bin(input logic [tapa_pkg::SEL_W-1:0] sel,
                          input logic [tapa_pkg::BIN_W-1:0] bin);
    send_item(tapa_pkg::FUNC_READ, tapa_pkg::PIX_W'($urandom),
              tapa_pkg::SPATIAL_W'($urandom), tapa_pkg::SPECTRAL_W'($urandom),
              sel, bin);
  endtask

  // One random item. In the hot mode the pixels pile onto a single column
  // with large values so that the sums run into saturation; reads then only
  // touch the slant stores, leaving the hot column to fill up.
  task automatic random_item(input bit hot,
                             input logic [tapa_pkg::SPATIAL_W-1:0] hot_sp);
    logic [tapa_pkg::PIX_W-1:0] pix;
    logic [tapa_pkg::SEL_W-1:0] sel;
    int                         depth;

    if (hot) begin
      pix = ($urandom_range(3) != 0) ? {tapa_pkg::PIX_W{1'b1}}
                                     : tapa_pkg::PIX_W'($urandom);
      if ($urandom_range(99) < 5) begin
        read_bin($urandom_range(1) ? tapa_pkg::ORDER_DIAG : tapa_pkg::ORDER_ANTI,
                 tapa_pkg::BIN_W'($urandom));
      end else begin
        accumulate(pix, hot_sp, tapa_pkg::SPECTRAL_W'($urandom_range(3)));
      end
    end else if ($urandom_range(99) < 80) begin
      case ($urandom_range(9))
        0:       pix = {tapa_pkg::PIX_W{1'b1}};
        1:       pix = '0;
        default: pix = tapa_pkg::PIX_W'($urandom);
      endcase
      accumulate(pix, tapa_pkg::SPATIAL_W'($urandom), tapa_pkg::SPECTRAL_W'($urandom));
    end else begin
      if ($urandom_range(19) == 0) begin
        sel = ORDER_NONE;
      end else begin
        case ($urandom_range(2))
          0:       sel = tapa_pkg::ORDER_COLUMN;
          1:       sel = tapa_pkg::ORDER_DIAG;
          default: sel = tapa_pkg::ORDER_ANTI;
        endcase
      end
      depth = (sel == tapa_pkg::ORDER_COLUMN) ? tapa_pkg::SPATIAL_SIZE
                                              : tapa_pkg::SLANT_BINS;
      if (sel != ORDER_NONE && $urandom_range(99) < 85) begin
        read_bin(sel, tapa_pkg::BIN_W'($urandom_range(depth - 1)));
      end else begin
        read_bin(sel, tapa_pkg::BIN_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [tapa_pkg::SPATIAL_W-1:0] hot_sp;

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.func           <= tapa_pkg::FUNC_ACCUM;
    in_ch.pixel_value    <= '0;
    in_ch.spatial_index  <= '0;
    in_ch.spectral_index <= '0;
    in_ch.order_select   <= tapa_pkg::ORDER_COLUMN;
    in_ch.bin_index      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Pixels at the corners of the image reach the first and
    // last bin of every store; the reads then hit both ends of each store,
    // re-read a bin that was just cleared, step one past the end of each
    // store, and use the selector that names no store.
    accumulate({tapa_pkg::PIX_W{1'b1}}, 8'd0, 6'd0);
    accumulate({tapa_pkg::PIX_W{1'b1}}, 8'd255, 6'd63);
    accumulate(16'd0, 8'd128, 6'd10);
    accumulate(16'd1, 8'd0, 6'd63);
    accumulate(16'h8000, 8'd255, 6'd0);
    read_bin(tapa_pkg::ORDER_COLUMN, 9'd0);
    read_bin(tapa_pkg::ORDER_COLUMN, 9'd255);
    read_bin(tapa_pkg::ORDER_COLUMN, 9'd0);
    read_bin(tapa_pkg::ORDER_DIAG, 9'd0);
    read_bin(tapa_pkg::ORDER_DIAG, 9'd318);
    read_bin(tapa_pkg::ORDER_DIAG, 9'd63);
    read_bin(tapa_pkg::ORDER_ANTI, 9'd0);
    read_bin(tapa_pkg::ORDER_ANTI, 9'd318);
    read_bin(tapa_pkg::ORDER_ANTI, 9'd255);
    read_bin(tapa_pkg::ORDER_COLUMN, 9'd256);
    read_bin(tapa_pkg::ORDER_COLUMN, 9'd511);
    read_bin(tapa_pkg::ORDER_DIAG, 9'd319);
    read_bin(tapa_pkg::ORDER_ANTI, 9'd319);
    read_bin(tapa_pkg::ORDER_ANTI, 9'd511);
    read_bin(ORDER_NONE, 9'd0);
    read_bin(ORDER_NONE, 9'd511);
    read_bin(tapa_pkg::ORDER_COLUMN, 9'd128);
    // Two hits on one bin and a read of it right behind them exercise the
    // forwarding path of the read-modify-write stage.
    steady = 1'b1;
    accumulate(16'd5, 8'd7, 6'd3);
    accumulate(16'd9, 8'd7, 6'd3);
    read_bin(tapa_pkg::ORDER_COLUMN, 9'd7);
    steady = 1'b0;

    repeat (600) random_item(1'b0, '0);

    // Hold the input back until every read has been answered.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reads_owed != 0) @(posedge clk);

    // A long stretch with no gaps and no stalls on either side.
    steady = 1'b1;
    repeat (300) random_item(1'b0, '0);
    steady = 1'b0;

    // Pile large pixels onto one column until it saturates, then read the
    // column and the slant bins it feeds.
    hot_sp = tapa_pkg::SPATIAL_W'($urandom);
    repeat (500) random_item(1'b1, hot_sp);
    read_bin(tapa_pkg::ORDER_COLUMN, tapa_pkg::BIN_W'(hot_sp));
    for (int sc = 0; sc < 4; sc++) begin
      read_bin(tapa_pkg::ORDER_DIAG,
               tapa_pkg::BIN_W'(int'(hot_sp) + tapa_pkg::SPECTRAL_SIZE - 1 - sc));
      read_bin(tapa_pkg::ORDER_ANTI, tapa_pkg::BIN_W'(int'(hot_sp) + sc));
    end

    repeat (300) random_item(1'b0, '0);

    // Drain: wait for the last answers, then a few cycles for anything stray.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reads_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS three_angle_projection_accumulator_unit");
    end else begin
      $display("FAIL three_angle_projection_accumulator_unit");
    end
    $finish;
  end

endmodule
